FILE: hw/rtl/phtlp_pkg.sv
// ----------------------------------------------------------------------------
// Pointer hash table package
// Table geometry, hash constant, status codes and controller states.
// ----------------------------------------------------------------------------
package phtlp_pkg;

    localparam int INDEX_BITS  = 10;
    localparam int TABLE_SLOTS = 1 << INDEX_BITS;
    localparam int DATA_W      = 64 + 1 + 64;

    localparam logic [63:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

    typedef logic [2:0] status_t;

    localparam status_t STATUS_INSERTED  = 3'd0;
    localparam status_t STATUS_FULL      = 3'd1;
    localparam status_t STATUS_REMOVED   = 3'd2;
    localparam status_t STATUS_NOT_FOUND = 3'd3;
    localparam status_t STATUS_ZERO_KEY  = 3'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_PROBE,
        ST_EMIT
    } state_t;

endpackage

FILE: hw/rtl/pointer_hash_table_linear_probe.sv
// ----------------------------------------------------------------------------
// Pointer hash table with linear probing
// Requests on the s_ channel insert or remove entries keyed by a 64-bit
// address; one result per request leaves on the m_ channel. Both channels
// use valid/ready. Keys live in a 64-bit slot memory, size, unified flag
// and handle in a second memory; both have one registered read port and
// one write port. After reset a clearing pass writes each of the
// 2^INDEX_BITS (1024) key slots to zero, one slot a cycle; s_ready stays
// low meanwhile.
// A request with a non-zero key is accepted, hashed in states ST_MUL0 to
// ST_MUL3 through a shared 32x32 multiplier, probed at one slot per cycle
// and then loaded into the output register.
// A zero key skips hashing and probing. Requests are handled one at a time.
// The result waits in its own register, so the next request is taken
// while the receiver stalls; a finished result waits for the output
// register to free up before the controller returns to idle.
// ----------------------------------------------------------------------------
module pointer_hash_table_linear_probe (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [63:0]          s_key,
    input  logic [63:0]          s_alloc_size,
    input  logic                 s_unified_flag,
    input  logic [63:0]          s_import_handle,
    output logic                 m_valid,
    input  logic                 m_ready,
    output phtlp_pkg::status_t   m_status,
    output logic [63:0]          m_got_size,
    output logic                 m_got_unified,
    output logic [63:0]          m_got_handle
);

    localparam int IB = phtlp_pkg::INDEX_BITS;
    localparam int DW = phtlp_pkg::DATA_W;

    logic [63:0] key_mem  [phtlp_pkg::TABLE_SLOTS];
    logic [DW-1:0] data_mem [phtlp_pkg::TABLE_SLOTS];

    phtlp_pkg::state_t state_reg, state_next;

    logic [IB-1:0] clr_reg, clr_next;
    logic [IB-1:0] probe_addr_reg, probe_addr_next;
    logic [IB-1:0] count_reg, count_next;

    logic          cmd_reg;
    logic [63:0]   key_reg, size_reg, handle_reg;
    logic          uni_reg;

    logic [63:0]   prod_reg, prod_next;
    logic [63:0]   acc_reg, acc_next;
    logic [31:0]   mul_a, mul_b;
    logic [31:0]   hash_hi;

    phtlp_pkg::status_t res_status_reg, res_status_next;
    logic [63:0]   res_size_reg, res_size_next;
    logic          res_uni_reg, res_uni_next;
    logic [63:0]   res_handle_reg, res_handle_next;

    logic          m_valid_reg, m_valid_next;
    phtlp_pkg::status_t m_status_reg;
    logic [63:0]   m_size_reg, m_handle_reg;
    logic          m_uni_reg;
    logic          m_load;

    logic [IB-1:0] rd_addr;
    logic [63:0]   key_rdata_reg;
    logic [DW-1:0] data_rdata_reg;

    logic          key_we;
    logic [IB-1:0] key_waddr;
    logic [63:0]   key_wdata;
    logic          data_we;

    logic          s_accept;

    assign s_accept      = s_valid && s_ready;
    assign hash_hi       = acc_reg[63:32] + prod_reg[31:0];
    assign prod_next     = 64'(mul_a) * 64'(mul_b);

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_got_size    = m_size_reg;
    assign m_got_unified = m_uni_reg;
    assign m_got_handle  = m_handle_reg;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        probe_addr_next = probe_addr_reg;
        count_next      = count_reg;
        acc_next        = acc_reg;
        mul_a           = key_reg[31:0];
        mul_b           = phtlp_pkg::FIB_MULT[31:0];
        res_status_next = res_status_reg;
        res_size_next   = res_size_reg;
        res_uni_next    = res_uni_reg;
        res_handle_next = res_handle_reg;
        rd_addr         = probe_addr_reg + IB'(1);
        key_we          = 1'b0;
        key_waddr       = probe_addr_reg;
        key_wdata       = '0;
        data_we         = 1'b0;
        s_ready         = 1'b0;
        m_load          = 1'b0;

        case (state_reg)
            phtlp_pkg::ST_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = clr_reg;
                clr_next  = clr_reg + IB'(1);
                if (clr_reg == '1) begin
                    state_next = phtlp_pkg::ST_IDLE;
                end
            end
            phtlp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_key == '0) begin
                        res_status_next = phtlp_pkg::STATUS_ZERO_KEY;
                        res_size_next   = '0;
                        res_uni_next    = 1'b0;
                        res_handle_next = '0;
                        state_next      = phtlp_pkg::ST_EMIT;
                    end else begin
                        state_next = phtlp_pkg::ST_MUL0;
                    end
                end
            end
            phtlp_pkg::ST_MUL0: begin
                state_next = phtlp_pkg::ST_MUL1;
            end
            phtlp_pkg::ST_MUL1: begin
                mul_a      = key_reg[63:32];
                acc_next   = prod_reg;
                state_next = phtlp_pkg::ST_MUL2;
            end
            phtlp_pkg::ST_MUL2: begin
                mul_b      = phtlp_pkg::FIB_MULT[63:32];
                acc_next   = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                state_next = phtlp_pkg::ST_MUL3;
            end
            phtlp_pkg::ST_MUL3: begin
                rd_addr         = hash_hi[31 -: IB];
                probe_addr_next = hash_hi[31 -: IB];
                count_next      = '0;
                state_next      = phtlp_pkg::ST_PROBE;
            end
            phtlp_pkg::ST_PROBE: begin
                probe_addr_next = probe_addr_reg + IB'(1);
                count_next      = count_reg + IB'(1);
                res_size_next   = '0;
                res_uni_next    = 1'b0;
                res_handle_next = '0;
                if (cmd_reg == phtlp_pkg::CMD_INSERT) begin
                    if (key_rdata_reg == '0) begin
                        key_we          = 1'b1;
                        key_wdata       = key_reg;
                        data_we         = 1'b1;
                        res_status_next = phtlp_pkg::STATUS_INSERTED;
                        state_next      = phtlp_pkg::ST_EMIT;
                    end else if (count_reg == '1) begin
                        res_status_next = phtlp_pkg::STATUS_FULL;
                        state_next      = phtlp_pkg::ST_EMIT;
                    end
                end else begin
                    if (key_rdata_reg == key_reg) begin
                        key_we          = 1'b1;
                        res_status_next = phtlp_pkg::STATUS_REMOVED;
                        res_size_next   = data_rdata_reg[DW-1 -: 64];
                        res_uni_next    = data_rdata_reg[64];
                        res_handle_next = data_rdata_reg[63:0];
                        state_next      = phtlp_pkg::ST_EMIT;
                    end else if (key_rdata_reg == '0 || count_reg == '1) begin
                        res_status_next = phtlp_pkg::STATUS_NOT_FOUND;
                        state_next      = phtlp_pkg::ST_EMIT;
                    end
                end
            end
            phtlp_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = phtlp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = phtlp_pkg::ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= phtlp_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg    <= s_cmd;
            key_reg    <= s_key;
            size_reg   <= s_alloc_size;
            uni_reg    <= s_unified_flag;
            handle_reg <= s_import_handle;
        end
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        probe_addr_reg <= probe_addr_next;
        count_reg      <= count_next;
        res_status_reg <= res_status_next;
        res_size_reg   <= res_size_next;
        res_uni_reg    <= res_uni_next;
        res_handle_reg <= res_handle_next;
        if (m_load) begin
            m_status_reg <= res_status_reg;
            m_size_reg   <= res_size_reg;
            m_uni_reg    <= res_uni_reg;
            m_handle_reg <= res_handle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[probe_addr_reg] <= {size_reg, uni_reg, handle_reg};
        end
        data_rdata_reg <= data_mem[rd_addr];
    end

endmodule
